### rtl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Command and result words, op codes, state encoding and cell packing.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// item kinds on the input channel
	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// character that moves the cursor to the next row
	localparam logic [7:0] NEWLINE_CODE = 8'h0a;
	localparam logic [7:0] BLANK_CHAR   = 8'h00;

	// configuration register indexes (paddr[2])
	localparam logic REG_DFLT_FG = 1'b0;
	localparam logic REG_DFLT_BG = 1'b1;

	// classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} tcw_op_t;

	typedef struct packed {
		tcw_op_t    op;
		logic [7:0] ch;
		logic [3:0] fg;
		logic [4:0] row;
		logic [6:0] col;
		logic       eot;
	} tcw_cmd_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [3:0] cell_fg;
		logic [3:0] cell_bg;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
		logic       scrolled;
		logic       text_done;
	} tcw_res_t;

	// back end sequencer states
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_REQ,
		ST_RD_DATA,
		ST_CLEAR,
		ST_SCROLL,
		ST_BLANK,
		ST_RESP
	} tcw_state_t;

	// cell layout: background, foreground, character
	function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [3:0] fg,
			input logic [3:0] bg);
		return {bg, fg, ch};
	endfunction

endpackage
`default_nettype wire

### rtl/tcw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### rtl/tcw_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_fifo: small register queue
// Push/full and pop/empty queue; words leave in arrival order.
// ----------------------------------------------------------------------------
module tcw_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + NW'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

### rtl/tcw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_front: input side of the console writer
// Accepts words, classifies them into commands and queues them for the back.
// ----------------------------------------------------------------------------
module tcw_front #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [1:0]       kind,
	input  wire logic [7:0]       char_code,
	input  wire logic [3:0]       fg_color,
	input  wire logic [4:0]       cell_row,
	input  wire logic [6:0]       cell_col,
	input  wire logic             end_of_text,
	input  wire logic             init_busy,
	output tcw_pkg::tcw_cmd_t     cmd,
	output logic                  cmd_empty,
	input  wire logic             cmd_pop
);

	localparam int CMD_W = $bits(tcw_pkg::tcw_cmd_t);

	tcw_pkg::tcw_cmd_t cmd_in;
	logic              q_full;
	logic              in_range;
	logic [CMD_W-1:0]  q_rdata;

	assign in_range = (32'(cell_row) < ROWS) && (32'(cell_col) < COLS);

	// classify the incoming word
	always_comb begin
		cmd_in     = '0;
		cmd_in.ch  = char_code;
		cmd_in.fg  = fg_color;
		cmd_in.row = cell_row;
		cmd_in.col = cell_col;
		unique case (kind)
			tcw_pkg::KIND_PUT: begin
				cmd_in.op  = (char_code == tcw_pkg::NEWLINE_CODE) ?
					tcw_pkg::OP_NEWLINE : tcw_pkg::OP_PUT;
				cmd_in.eot = end_of_text;
			end
			tcw_pkg::KIND_READ: begin
				cmd_in.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
			end
			tcw_pkg::KIND_CLEAR: begin
				cmd_in.op = tcw_pkg::OP_CLEAR;
			end
			default: begin
				cmd_in.op = tcw_pkg::OP_NOP;
			end
		endcase
	end

	// no words taken while the screen is being cleared after reset
	assign full = q_full || init_busy;

	// command queue between front and back
	tcw_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !init_busy),
		.wdata (cmd_in),
		.full  (q_full),
		.pop   (cmd_pop),
		.rdata (q_rdata),
		.empty (cmd_empty)
	);

	assign cmd = tcw_pkg::tcw_cmd_t'(q_rdata);

endmodule
`default_nettype wire

### rtl/tcw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_back: execution side of the console writer
// Owns the cursor and the screen RAM; runs puts, reads, clears and scrolls.
// ----------------------------------------------------------------------------
module tcw_back #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [3:0]        dflt_fg,
	input  wire logic [3:0]        dflt_bg,
	input  wire tcw_pkg::tcw_cmd_t cmd,
	input  wire logic              cmd_empty,
	output logic                   cmd_pop,
	output tcw_pkg::tcw_res_t      res,
	output logic                   res_push,
	input  wire logic              res_full,
	output logic                   init_busy
);

	localparam int CELLS = ROWS * COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);

	localparam logic [AW-1:0] LAST_ADDR     = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_ROW_ADDR = AW'((ROWS - 1) * COLS);
	localparam logic [AW-1:0] COPY_LAST     = AW'((ROWS - 1) * COLS - 1);
	localparam logic [AW-1:0] ROW_STEP      = AW'(COLS);
	localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL      = CW'(COLS - 1);

	tcw_pkg::tcw_state_t state_q;
	tcw_pkg::tcw_state_t state_d;
	tcw_pkg::tcw_cmd_t   cmd_q;

	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [AW-1:0]   addr_q;
	logic [AW-1:0]   cnt_q;
	logic [AW-1:0]   rd_addr_q;
	logic [15:0]     cell_q;
	logic            scrolled_q;
	logic            done_q;

	logic            cp_vld_s1;
	logic            cp_blank_s1;
	logic [AW-1:0]   cp_addr_s1;

	logic            fill_we;
	logic            put_we;
	logic            last_row;
	logic            last_col;
	logic            put_scroll;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [15:0]     ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [15:0]     ram_rdata;

	logic [RW+4:0]   row_wide;
	logic [CW+6:0]   col_wide;

	assign last_row   = (row_q == LAST_ROW);
	assign last_col   = (col_q == LAST_COL);
	assign put_scroll = last_row && last_col;
	assign init_busy  = (state_q == tcw_pkg::ST_INIT);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshakes
	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		fill_we  = 1'b0;
		put_we   = 1'b0;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				fill_we = 1'b1;
				if (cnt_q == LAST_ADDR) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						tcw_pkg::OP_PUT: begin
							put_we  = 1'b1;
							state_d = put_scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_RESP;
						end
						tcw_pkg::OP_NEWLINE: begin
							state_d = last_row ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_RESP;
						end
						tcw_pkg::OP_READ:  state_d = tcw_pkg::ST_RD_ADDR;
						tcw_pkg::OP_CLEAR: state_d = tcw_pkg::ST_CLEAR;
						default:           state_d = tcw_pkg::ST_RESP;
					endcase
				end
			end
			tcw_pkg::ST_RD_ADDR: state_d = tcw_pkg::ST_RD_REQ;
			tcw_pkg::ST_RD_REQ:  state_d = tcw_pkg::ST_RD_DATA;
			tcw_pkg::ST_RD_DATA: state_d = tcw_pkg::ST_RESP;
			tcw_pkg::ST_CLEAR: begin
				fill_we = 1'b1;
				if (cnt_q == LAST_ADDR) state_d = tcw_pkg::ST_RESP;
			end
			tcw_pkg::ST_SCROLL: begin
				if (cnt_q == COPY_LAST) state_d = tcw_pkg::ST_BLANK;
			end
			tcw_pkg::ST_BLANK: begin
				if (cnt_q == LAST_ADDR) state_d = tcw_pkg::ST_RESP;
			end
			tcw_pkg::ST_RESP: begin
				res_push = 1'b1;
				state_d  = tcw_pkg::ST_IDLE;
			end
			default: state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	// cursor, sweep counter and copy stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			addr_q    <= '0;
			cnt_q     <= '0;
			cp_vld_s1 <= 1'b0;
		end else begin
			cp_vld_s1 <= (state_q == tcw_pkg::ST_SCROLL) || (state_q == tcw_pkg::ST_BLANK);
			if (state_q == tcw_pkg::ST_IDLE) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (cmd_pop) begin
				case (cmd.op)
					tcw_pkg::OP_PUT: begin
						if (put_scroll) begin
							col_q  <= '0;
							addr_q <= LAST_ROW_ADDR;
						end else if (last_col) begin
							col_q  <= '0;
							row_q  <= row_q + RW'(1);
							addr_q <= addr_q + AW'(1);
						end else begin
							col_q  <= col_q + CW'(1);
							addr_q <= addr_q + AW'(1);
						end
					end
					tcw_pkg::OP_NEWLINE: begin
						col_q <= '0;
						if (last_row) begin
							addr_q <= LAST_ROW_ADDR;
						end else begin
							row_q  <= row_q + RW'(1);
							addr_q <= addr_q - AW'(col_q) + ROW_STEP;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// command, result and copy stage payload
	always_ff @(posedge clk) begin
		cp_blank_s1 <= (state_q == tcw_pkg::ST_BLANK);
		cp_addr_s1  <= cnt_q;
		if (cmd_pop) begin
			cmd_q      <= cmd;
			cell_q     <= '0;
			scrolled_q <= ((cmd.op == tcw_pkg::OP_PUT) && put_scroll) ||
				((cmd.op == tcw_pkg::OP_NEWLINE) && last_row);
			done_q     <= cmd.eot;
		end
		if (state_q == tcw_pkg::ST_RD_ADDR) begin
			rd_addr_q <= AW'(32'(cmd_q.row) * COLS + 32'(cmd_q.col));
		end
		if (state_q == tcw_pkg::ST_RD_DATA) begin
			cell_q <= ram_rdata;
		end
	end

	// ram write port: copy stage, fill sweep, then put
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = tcw_pkg::make_cell(cmd.ch, cmd.fg, dflt_bg);
		if (cp_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_addr_s1;
			ram_wdata = tcw_pkg::make_cell(cp_blank_s1 ? tcw_pkg::BLANK_CHAR : ram_rdata[7:0],
				dflt_fg, dflt_bg);
		end else if (fill_we) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
			ram_wdata = init_busy ? 16'h0000 :
				tcw_pkg::make_cell(tcw_pkg::BLANK_CHAR, dflt_fg, dflt_bg);
		end else if (put_we) begin
			ram_we = 1'b1;
		end
	end

	// ram read port: row below during scroll, else the read address
	assign ram_raddr = (state_q == tcw_pkg::ST_SCROLL) ? cnt_q + ROW_STEP : rd_addr_q;

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// result word
	assign row_wide = {5'd0, row_q};
	assign col_wide = {7'd0, col_q};

	always_comb begin
		res.cell_char  = cell_q[7:0];
		res.cell_fg    = cell_q[11:8];
		res.cell_bg    = cell_q[15:12];
		res.cursor_row = row_wide[4:0];
		res.cursor_col = col_wide[6:0];
		res.scrolled   = scrolled_q;
		res.text_done  = done_q;
	end

	// a result is only pushed when the output queue has room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full output queue");

	// copy stage writes only during or right after a scroll
	a_copy_window: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> (state_q == tcw_pkg::ST_SCROLL || state_q == tcw_pkg::ST_BLANK ||
			state_q == tcw_pkg::ST_RESP))
		else $error("copy write outside scroll");

	// cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= LAST_ROW) && (col_q <= LAST_COL))
		else $error("cursor off screen");

	// linear cursor address tracks row and column
	a_addr_track: assert property (@(posedge clk) disable iff (!arst_n)
		addr_q == AW'(32'(row_q) * COLS + 32'(col_q)))
		else $error("cursor address out of step");

endmodule
`default_nettype wire

### rtl/text_console_writer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_unit: text-mode console engine
// Writes characters into a ROWS by COLS screen of 16-bit cells with scrolling.
// ----------------------------------------------------------------------------
// Input words enter through push/full and carry kind, char_code, fg_color,
// cell_row, cell_col and end_of_text. A word is taken when push is high and
// full is low. Each word gives exactly one result word, held on the result
// ports while empty is low and taken when pop is high.
// The front classifies words into a two-entry command queue; the back runs
// them against the screen RAM (one write, one registered read port).
// In the back, a read passes through the address, request and data states;
// a clear sweeps all ROWS*COLS cells, and a scrolling put or newline copies
// the rows up and blanks the last row, one cell per cycle through the single RAM write port.
// After reset the back sweeps all ROWS*COLS cells to zero, one per cycle;
// full stays high until the sweep is done. Configuration writes are taken
// at any time over the APB port.
// A stalled receiver fills the two-entry result queue; the back then holds
// its next command and the command queue fills until full rises.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input queue
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  char_code,
	input  wire logic [3:0]  fg_color,
	input  wire logic [4:0]  cell_row,
	input  wire logic [6:0]  cell_col,
	input  wire logic        end_of_text,
	// result queue
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       cell_char,
	output logic [3:0]       cell_fg,
	output logic [3:0]       cell_bg,
	output logic [4:0]       cursor_row,
	output logic [6:0]       cursor_col,
	output logic             scrolled,
	output logic             text_done,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int RES_W = $bits(tcw_pkg::tcw_res_t);

	logic [3:0]        dflt_fg_q;
	logic [3:0]        dflt_bg_q;
	logic              cfg_we;
	logic              init_busy;
	tcw_pkg::tcw_cmd_t cmd;
	logic              cmd_empty;
	logic              cmd_pop;
	tcw_pkg::tcw_res_t res;
	logic              res_push;
	logic              res_full;
	logic [RES_W-1:0]  res_rdata;
	tcw_pkg::tcw_res_t res_out;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_fg_q <= 4'd7;
			dflt_bg_q <= 4'd0;
		end else if (cfg_we) begin
			case (paddr[2])
				tcw_pkg::REG_DFLT_FG: dflt_fg_q <= pwdata[3:0];
				default:              dflt_bg_q <= pwdata[3:0];
			endcase
		end
	end

	assign prdata = (paddr[2] == tcw_pkg::REG_DFLT_BG) ? {28'd0, dflt_bg_q} : {28'd0, dflt_fg_q};

	// front: accept and classify
	tcw_front #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.char_code  (char_code),
		.fg_color   (fg_color),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.end_of_text(end_of_text),
		.init_busy  (init_busy),
		.cmd        (cmd),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop)
	);

	// back: cursor, screen and sequencer
	tcw_back #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.dflt_fg  (dflt_fg_q),
		.dflt_bg  (dflt_bg_q),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res      (res),
		.res_push (res_push),
		.res_full (res_full),
		.init_busy(init_busy)
	);

	// result queue
	tcw_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign res_out    = tcw_pkg::tcw_res_t'(res_rdata);
	assign cell_char  = res_out.cell_char;
	assign cell_fg    = res_out.cell_fg;
	assign cell_bg    = res_out.cell_bg;
	assign cursor_row = res_out.cursor_row;
	assign cursor_col = res_out.cursor_col;
	assign scrolled   = res_out.scrolled;
	assign text_done  = res_out.text_done;

endmodule
`default_nettype wire

### tb/text_console_writer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_unit_test: self-checking bench for the text console
// Drives put, read, clear and unused words through the input queue, follows
// the screen and cursor in a model of its own and checks every result word
// field by field. The default colors are set over the APB port between
// phases, with random idling on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module text_console_writer_unit_test;

	localparam int ROWS = 25;
	localparam int COLS = 80;
	localparam int CELLS = ROWS * COLS;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int PHASES = 4;
	localparam int PHASE_WORDS = 212;
	localparam int HOLD_CYCLES = 100;
	localparam int DRAIN_CYCLES = 50;
	localparam int PRINT_CAP = 200;

	// one word of stimulus, with an optional hand-written expectation
	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        ch;
		logic [3:0]        fg;
		logic [4:0]        row;
		logic [6:0]        col;
		logic              eot;
		logic              typed;
		tcw_pkg::tcw_res_t want;
	} console_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  kind = tcw_pkg::KIND_PUT;
	logic [7:0]  char_code = 8'h00;
	logic [3:0]  fg_color = 4'h0;
	logic [4:0]  cell_row = 5'd0;
	logic [6:0]  cell_col = 7'd0;
	logic        end_of_text = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  cell_char;
	logic [3:0]  cell_fg;
	logic [3:0]  cell_bg;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_col;
	logic        scrolled;
	logic        text_done;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// screen and cursor as the bench sees them
	logic [15:0] screen_model [0:CELLS-1];
	int unsigned crow = 0;
	int unsigned ccol = 0;
	logic [3:0]  dflt_fg = 4'd7;
	logic [3:0]  dflt_bg = 4'd0;

	tcw_pkg::tcw_res_t words_due [$];
	tcw_pkg::tcw_res_t due_word;
	console_word_t     opening_words [$];

	int  error_count = 0;
	int  words_sent = 0;
	int  words_checked = 0;
	int  stall_cycles = 0;
	int  reads_seen = 0;
	int  clears_seen = 0;
	int  scrolls_seen = 0;
	int  wraps_seen = 0;
	int  settings_seen = 0;
	bit  idle_on = 1'b1;
	bit  hold_request = 1'b0;

	text_console_writer_unit #(
		.ROWS(ROWS),
		.COLS(COLS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.char_code(char_code),
		.fg_color(fg_color),
		.cell_row(cell_row),
		.cell_col(cell_col),
		.end_of_text(end_of_text),
		.empty(empty),
		.pop(pop),
		.cell_char(cell_char),
		.cell_fg(cell_fg),
		.cell_bg(cell_bg),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.scrolled(scrolled),
		.text_done(text_done),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// one line per mismatch, printing capped, counting not
	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (error_count < PRINT_CAP) begin
			$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		end
		error_count++;
	endtask

	task automatic check_field(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want) begin
			report_mismatch(what, got, want);
		end
	endtask

	function automatic tcw_pkg::tcw_res_t cell_result(input logic [7:0] ch,
			input logic [3:0] fg, input logic [3:0] bg, input logic [4:0] row,
			input logic [6:0] col, input logic scr, input logic done);
		tcw_pkg::tcw_res_t r;
		r.cell_char = ch;
		r.cell_fg = fg;
		r.cell_bg = bg;
		r.cursor_row = row;
		r.cursor_col = col;
		r.scrolled = scr;
		r.text_done = done;
		return r;
	endfunction

	// each row takes the characters from below with default colors
	function automatic void scroll_screen();
		for (int r = 0; r + 1 < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				screen_model[r * COLS + c] = {dflt_bg, dflt_fg,
					screen_model[(r + 1) * COLS + c][7:0]};
			end
		end
		for (int c = 0; c < COLS; c++) begin
			screen_model[(ROWS - 1) * COLS + c] = {dflt_bg, dflt_fg, tcw_pkg::BLANK_CHAR};
		end
		scrolls_seen++;
	endfunction

	// applies one word to the screen copy and returns the result word it gives
	function automatic tcw_pkg::tcw_res_t console_step(input logic [1:0] k,
			input logic [7:0] ch, input logic [3:0] fg, input logic [4:0] rr,
			input logic [6:0] rc, input logic eot);
		tcw_pkg::tcw_res_t r;
		logic [15:0] scr_word;
		bit last_row;
		r = '0;
		last_row = (crow == ROWS - 1);
		case (k)
			tcw_pkg::KIND_PUT: begin
				r.text_done = eot;
				if (ch == tcw_pkg::NEWLINE_CODE) begin
					if (last_row) begin
						scroll_screen();
						r.scrolled = 1'b1;
					end else begin
						crow++;
					end
					ccol = 0;
				end else begin
					screen_model[crow * COLS + ccol] = {dflt_bg, fg, ch};
					if (last_row && ccol == COLS - 1) begin
						// last cell of the screen: scroll, back to start of last row
						scroll_screen();
						r.scrolled = 1'b1;
						ccol = 0;
					end else if (ccol + 1 >= COLS) begin
						ccol = 0;
						crow++;
						wraps_seen++;
					end else begin
						ccol++;
					end
				end
			end
			tcw_pkg::KIND_READ: begin
				reads_seen++;
				if (rr < ROWS && rc < COLS) begin
					scr_word = screen_model[rr * COLS + rc];
					r.cell_char = scr_word[7:0];
					r.cell_fg = scr_word[11:8];
					r.cell_bg = scr_word[15:12];
				end
			end
			tcw_pkg::KIND_CLEAR: begin
				clears_seen++;
				for (int i = 0; i < CELLS; i++) begin
					screen_model[i] = {dflt_bg, dflt_fg, tcw_pkg::BLANK_CHAR};
				end
			end
			default: ;
		endcase
		r.cursor_row = crow[4:0];
		r.cursor_col = ccol[6:0];
		return r;
	endfunction

	function automatic void add_opening_word(input logic [1:0] k, input logic [7:0] ch,
			input logic [3:0] fg, input logic [4:0] rr, input logic [6:0] rc,
			input logic eot, input logic typed, input tcw_pkg::tcw_res_t want);
		console_word_t w;
		w.kind = k;
		w.ch = ch;
		w.fg = fg;
		w.row = rr;
		w.col = rc;
		w.eot = eot;
		w.typed = typed;
		w.want = want;
		opening_words.push_back(w);
	endfunction

	function automatic console_word_t random_word();
		console_word_t w;
		w.kind = 2'($urandom_range(0, 3));
		w.ch = 8'($urandom_range(0, 255));
		w.fg = 4'($urandom_range(0, 15));
		w.row = 5'($urandom_range(0, 31));
		w.col = 7'($urandom_range(0, 127));
		w.eot = 1'($urandom_range(0, 1));
		w.typed = 1'b0;
		w.want = '0;
		return w;
	endfunction

	// offer one word until taken, then log what it should give
	task automatic send_word(input console_word_t w);
		tcw_pkg::tcw_res_t guess;
		push <= 1'b1;
		kind <= w.kind;
		char_code <= w.ch;
		fg_color <= w.fg;
		cell_row <= w.row;
		cell_col <= w.col;
		end_of_text <= w.eot;
		@(posedge clk);
		while (full) begin
			stall_cycles++;
			@(posedge clk);
		end
		guess = console_step(w.kind, w.ch, w.fg, w.row, w.col, w.eot);
		words_due.push_back(w.typed ? w.want : guess);
		words_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// apb transfers leave psel high so back-to-back setups need no idle
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
	endtask

	task automatic wait_for_idle();
		push <= 1'b0;
		while (words_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// set both default colors and read them back
	task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
		logic [31:0] rd;
		apb_write({tcw_pkg::REG_DFLT_FG, 2'b00}, {28'($urandom), fg});
		dflt_fg = fg;
		apb_write({tcw_pkg::REG_DFLT_BG, 2'b00}, {28'($urandom), bg});
		dflt_bg = bg;
		apb_read({tcw_pkg::REG_DFLT_FG, 2'b00}, rd);
		check_field("default_foreground readback", {4'd0, rd[3:0]}, {4'd0, fg});
		apb_read({tcw_pkg::REG_DFLT_BG, 2'b00}, rd);
		check_field("default_background readback", {4'd0, rd[3:0]}, {4'd0, bg});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		settings_seen++;
	endtask

	// a run of text ending in a newline, sometimes long enough to wrap
	task automatic send_text_line();
		console_word_t w;
		int len;
		int pick;
		pick = $urandom_range(0, 99);
		len = (pick < 55) ? $urandom_range(0, 8) :
			(pick < 85) ? $urandom_range(9, 40) : $urandom_range(75, 90);
		for (int i = 0; i < len; i++) begin
			w = random_word();
			w.kind = tcw_pkg::KIND_PUT;
			if ($urandom_range(0, 9) != 0) begin
				w.ch = 8'($urandom_range(32, 126));
			end
			// keep newlines out of the body of the line
			if (w.ch == tcw_pkg::NEWLINE_CODE) begin
				w.ch = w.ch ^ 8'h01;
			end
			w.eot = (i == len - 1);
			send_word(w);
		end
		w = random_word();
		w.kind = tcw_pkg::KIND_PUT;
		w.ch = tcw_pkg::NEWLINE_CODE;
		send_word(w);
	endtask

	task automatic send_reads();
		console_word_t w;
		int n;
		int pick;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			w = random_word();
			w.kind = tcw_pkg::KIND_READ;
			pick = $urandom_range(0, 99);
			if (pick >= 15) begin
				// mostly near the cursor, where the text has just gone
				if (pick < 60) begin
					w.row = (crow > 0 && $urandom_range(0, 1)) ? 5'(crow - 1) : 5'(crow);
				end else begin
					w.row = 5'($urandom_range(0, ROWS - 1));
				end
				w.col = 7'($urandom_range(0, COLS - 1));
			end
			send_word(w);
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				pop <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// compare each taken result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (words_due.size() == 0) begin
				report_mismatch("result word with nothing expected", {1'b0, cursor_col}, 8'd0);
			end else begin
				due_word = words_due.pop_front();
				check_field("cell_char", cell_char, due_word.cell_char);
				check_field("cell_fg", {4'd0, cell_fg}, {4'd0, due_word.cell_fg});
				check_field("cell_bg", {4'd0, cell_bg}, {4'd0, due_word.cell_bg});
				check_field("cursor_row", {3'd0, cursor_row}, {3'd0, due_word.cursor_row});
				check_field("cursor_col", {1'b0, cursor_col}, {1'b0, due_word.cursor_col});
				check_field("scrolled", {7'd0, scrolled}, {7'd0, due_word.scrolled});
				check_field("text_done", {7'd0, text_done}, {7'd0, due_word.text_done});
				words_checked++;
			end
		end
	end

	// main sequence
	initial begin
		console_word_t w;
		int phase_start;
		int pick;
		for (int i = 0; i < CELLS; i++) begin
			screen_model[i] = 16'h0000;
		end

		// opening table: reset state, field extremes, every kind
		add_opening_word(tcw_pkg::KIND_READ, 8'h00, 4'h0, 5'd0, 7'd0, 1'b0, 1'b1,
			cell_result(8'h00, 4'h0, 4'h0, 5'd0, 7'd0, 1'b0, 1'b0));
		add_opening_word(tcw_pkg::KIND_READ, 8'hff, 4'hf, 5'd24, 7'd79, 1'b0, 1'b1,
			cell_result(8'h00, 4'h0, 4'h0, 5'd0, 7'd0, 1'b0, 1'b0));
		add_opening_word(tcw_pkg::KIND_READ, 8'h00, 4'h0, 5'd25, 7'd0, 1'b0, 1'b1,
			cell_result(8'h00, 4'h0, 4'h0, 5'd0, 7'd0, 1'b0, 1'b0));
		add_opening_word(tcw_pkg::KIND_READ, 8'h00, 4'h0, 5'd0, 7'd80, 1'b0, 1'b1,
			cell_result(8'h00, 4'h0, 4'h0, 5'd0, 7'd0, 1'b0, 1'b0));
		add_opening_word(tcw_pkg::KIND_READ, 8'h00, 4'h0, 5'd31, 7'd127, 1'b1, 1'b1,
			cell_result(8'h00, 4'h0, 4'h0, 5'd0, 7'd0, 1'b0, 1'b0));
		add_opening_word(tcw_pkg::KIND_PUT, 8'h41, 4'hf, 5'd31, 7'd127, 1'b1, 1'b1,
			cell_result(8'h00, 4'h0, 4'h0, 5'd0, 7'd1, 1'b0, 1'b1));
		add_opening_word(tcw_pkg::KIND_READ, 8'h00, 4'h0, 5'd0, 7'd0, 1'b1, 1'b1,
			cell_result(8'h41, 4'hf, 4'h0, 5'd0, 7'd1, 1'b0, 1'b0));
		add_opening_word(tcw_pkg::KIND_PUT, 8'hff, 4'h0, 5'd0, 7'd0, 1'b0, 1'b1,
			cell_result(8'h00, 4'h0, 4'h0, 5'd0, 7'd2, 1'b0, 1'b0));
		add_opening_word(tcw_pkg::KIND_PUT, 8'h00, 4'h9, 5'd3, 7'd5, 1'b1, 1'b0, '0);
		add_opening_word(tcw_pkg::KIND_READ, 8'h00, 4'h0, 5'd0, 7'd1, 1'b0, 1'b0, '0);
		add_opening_word(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_CODE, 4'h5, 5'd0, 7'd0, 1'b1,
			1'b1, cell_result(8'h00, 4'h0, 4'h0, 5'd1, 7'd0, 1'b0, 1'b1));
		add_opening_word(tcw_pkg::KIND_READ, 8'h00, 4'h0, 5'd0, 7'd3, 1'b0, 1'b0, '0);
		add_opening_word(KIND_UNUSED, tcw_pkg::NEWLINE_CODE, 4'hf, 5'd31, 7'd127, 1'b1, 1'b1,
			cell_result(8'h00, 4'h0, 4'h0, 5'd1, 7'd0, 1'b0, 1'b0));
		add_opening_word(tcw_pkg::KIND_PUT, 8'h7e, 4'h3, 5'd0, 7'd0, 1'b0, 1'b0, '0);
		add_opening_word(tcw_pkg::KIND_CLEAR, 8'hff, 4'hf, 5'd0, 7'd0, 1'b1, 1'b1,
			cell_result(8'h00, 4'h0, 4'h0, 5'd1, 7'd1, 1'b0, 1'b0));
		add_opening_word(tcw_pkg::KIND_READ, 8'h00, 4'h0, 5'd1, 7'd0, 1'b0, 1'b1,
			cell_result(8'h00, 4'h7, 4'h0, 5'd1, 7'd1, 1'b0, 1'b0));
		add_opening_word(tcw_pkg::KIND_READ, 8'h00, 4'h0, 5'd24, 7'd79, 1'b0, 1'b0, '0);
		add_opening_word(tcw_pkg::KIND_PUT, 8'h80, 4'hc, 5'd0, 7'd0, 1'b0, 1'b0, '0);

		// reset, then the block sweeps its store before taking words
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_words[i]) begin
			send_word(opening_words[i]);
		end
		wait_for_idle();

		// random phases, each under its own pair of default colors
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_colors(4'h0, 4'h0);
				1: set_colors(4'hf, 4'hf);
				2: set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
				default: set_colors(4'hf, 4'h0);
			endcase
			idle_on = (p < PHASES - 1);
			if (p == 0) begin
				hold_request = 1'b1;
			end
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					send_text_line();
				end else if (pick < 65) begin
					repeat ($urandom_range(1, 4)) begin
						w = random_word();
						w.kind = tcw_pkg::KIND_PUT;
						w.ch = tcw_pkg::NEWLINE_CODE;
						send_word(w);
					end
				end else if (pick < 85) begin
					send_reads();
				end else if (pick < 97) begin
					// noise: any kind, any field values
					repeat ($urandom_range(1, 3)) send_word(random_word());
				end else begin
					w = random_word();
					w.kind = tcw_pkg::KIND_CLEAR;
					send_word(w);
				end
			end
			wait_for_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d words checked: %0d reads, %0d clears, %0d scrolls, %0d row wraps",
			words_checked, reads_seen, clears_seen, scrolls_seen, wraps_seen);
		$display("%0d color settings; input held off %0d cycles by a full queue",
			settings_seen, stall_cycles);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// guard against a hung block
	initial begin
		#(80_000_000);
		$display("timeout with %0d result words still expected", words_due.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_fifo.sv
rtl/tcw_front.sv
rtl/tcw_back.sv
rtl/text_console_writer_unit.sv
tb/text_console_writer_unit_test.sv
